FILE: hw/rtl/xsf_pkg.sv
// ----------------------------------------------------------------------------
// xsf_pkg: shared types and constants
// Command codes, the decoded operation that passes from the front end to the
// row engine, and the default screen size.
// ----------------------------------------------------------------------------
package xsf_pkg;

  // default screen size in pixels
  localparam int DEF_SCREEN_WIDTH  = 64;
  localparam int DEF_SCREEN_HEIGHT = 32;

  // widths that hold a column or a row at the largest allowed screen
  localparam int COL_W = 6;
  localparam int ROW_W = 6;
  // column group number on a read (pos_x / 8)
  localparam int GRP_W = 5;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // one decoded operation, as held in the queue
  typedef struct packed {
    cmd_e             cmd;
    logic [COL_W-1:0] col;     // pos_x mod width
    logic [ROW_W-1:0] row;     // target row, already wrapped when wrap is on
    logic             skip;    // draw row lies below the screen in clip mode
    logic [GRP_W-1:0] grp;     // column group on a read
    logic [7:0]       bits;    // sprite pixels, bit 7 leftmost
    logic             first;
    logic             last;
  } xsf_op_t;

endpackage

FILE: hw/rtl/xsf_front.sv
// ----------------------------------------------------------------------------
// xsf_front: command decode
// Reduces the raw coordinates modulo the screen size, works out the target
// row of a draw and whether it falls off the bottom edge.
// ----------------------------------------------------------------------------
module xsf_front
  import xsf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic [1:0] cmd_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic [3:0] row_index_i,
  input  logic [7:0] sprite_byte_i,
  input  logic       first_row_i,
  input  logic       last_row_i,
  input  logic       wrap_i,
  output xsf_op_t    op_o
);

  localparam int CW = $clog2(SCREEN_WIDTH);
  localparam int RW = $clog2(SCREEN_HEIGHT);
  // holds (y mod height) + row_index
  localparam int SW = $clog2(SCREEN_HEIGHT + 15);

  logic [CW-1:0] xmod_tbl [256];
  logic [RW-1:0] ymod_tbl [256];
  logic [RW-1:0] sum_tbl  [2**SW];

  logic [CW-1:0] x0;
  logic [RW-1:0] y0;
  logic [SW-1:0] y_sum;
  logic [RW-1:0] row;

  // constant remainder tables
  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign xmod_tbl[i] = CW'(i % SCREEN_WIDTH);
    assign ymod_tbl[i] = RW'(i % SCREEN_HEIGHT);
  end
  for (genvar i = 0; i < 2**SW; i++) begin : g_sum
    assign sum_tbl[i] = RW'(i % SCREEN_HEIGHT);
  end

  // coordinate reduction
  assign x0    = xmod_tbl[pos_x_i];
  assign y0    = ymod_tbl[pos_y_i];
  assign y_sum = SW'(y0) + SW'(row_index_i);

  // draw row address, read row address
  always_comb begin
    if (cmd_e'(cmd_i) == CMD_READ) begin
      row = y0;
    end else if (wrap_i) begin
      row = sum_tbl[y_sum];
    end else begin
      row = y_sum[RW-1:0];
    end
  end

  // pack the operation
  always_comb begin
    op_o.cmd   = cmd_e'(cmd_i);
    op_o.col   = COL_W'(x0);
    op_o.row   = ROW_W'(row);
    op_o.skip  = !wrap_i && (y_sum >= SW'(SCREEN_HEIGHT));
    op_o.grp   = pos_x_i[7:3];
    op_o.bits  = sprite_byte_i;
    op_o.first = first_row_i;
    op_o.last  = last_row_i;
  end

endmodule

FILE: hw/rtl/xsf_queue.sv
// ----------------------------------------------------------------------------
// xsf_queue: two-entry operation queue
// Decouples command decode from the row engine.
// ----------------------------------------------------------------------------
module xsf_queue
  import xsf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  xsf_op_t item_i,
  output logic    full_o,
  input  logic    pop_i,
  output xsf_op_t head_o,
  output logic    empty_o
);

  xsf_op_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: hw/rtl/xsf_back.sv
// ----------------------------------------------------------------------------
// xsf_back: framebuffer row engine
// Holds the frame rows, runs read-modify-write of one row per draw, reads
// pixel groups, clears the screen and keeps the collision flag.
// ----------------------------------------------------------------------------
module xsf_back
  import xsf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wrap_i,
  input  xsf_op_t    head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic       m_collision_o,
  output logic       m_done_o,
  output logic [7:0] m_group_o
);

  localparam int CW  = $clog2(SCREEN_WIDTH);
  localparam int RW  = $clog2(SCREEN_HEIGHT);
  localparam int PXW = $clog2(2 * SCREEN_WIDTH);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  xsf_op_t op_q;
  logic coll_q;
  logic out_valid_q;
  logic out_coll_q;
  logic out_done_q;
  logic [7:0] out_group_q;
  logic [SCREEN_HEIGHT-1:0] row_vld_q;
  logic rd_vld_q;

  logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];
  logic [SCREEN_WIDTH-1:0] rd_data_q;

  logic [SCREEN_WIDTH-1:0] row_data;
  logic [SCREEN_WIDTH-1:0] mask;
  logic [SCREEN_WIDTH-1:0] new_row;
  logic [CW-1:0] x0;
  logic [RW-1:0] op_row;
  logic hit;
  logic exec_go;
  logic wr_en;
  logic coll_nxt;
  logic done_nxt;
  logic [7:0] group_nxt;

  assign x0      = op_q.col[CW-1:0];
  assign op_row  = op_q.row[RW-1:0];
  assign row_data = rd_vld_q ? rd_data_q : '0;
  assign pop_o   = (state_q == ST_IDLE) && !empty_i;
  assign exec_go = (state_q == ST_EXEC) && (!out_valid_q || m_ready_i);

  // sprite pixel mask over the row, wrapped or clipped at the right edge
  always_comb begin
    logic [PXW-1:0] px;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      px = PXW'(x0) + PXW'(b);
      if (op_q.bits[7-b]) begin
        if (px >= PXW'(SCREEN_WIDTH)) begin
          if (wrap_i) begin
            mask[CW'(px - PXW'(SCREEN_WIDTH))] = 1'b1;
          end
        end else begin
          mask[px[CW-1:0]] = 1'b1;
        end
      end
    end
  end

  assign hit     = |(row_data & mask);
  assign new_row = row_data ^ mask;
  assign wr_en   = exec_go && (op_q.cmd == CMD_DRAW) && !op_q.skip;

  // result of the current operation
  always_comb begin
    logic [7:0] c;
    coll_nxt  = coll_q;
    done_nxt  = 1'b0;
    group_nxt = 8'd0;
    case (op_q.cmd)
      CMD_DRAW: begin
        coll_nxt = (op_q.first ? 1'b0 : coll_q) | (!op_q.skip && hit);
        done_nxt = op_q.last;
      end
      CMD_READ: begin
        for (int b = 0; b < 8; b++) begin
          c = {op_q.grp, 3'(b)};
          if (c < 8'(SCREEN_WIDTH)) begin
            group_nxt[7-b] = row_data[c[CW-1:0]];
          end
        end
      end
      default: begin
        coll_nxt = coll_q;
      end
    endcase
  end

  // row memory, registered read
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_data_q <= frame_mem[head_i.row[RW-1:0]];
    end
    if (wr_en) begin
      frame_mem[op_row] <= new_row;
    end
  end

  // operation payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q <= head_i;
    end
  end

  // sequencer, row valid bits, flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      coll_q      <= 1'b0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_coll_q  <= 1'b0;
      out_done_q  <= 1'b0;
      out_group_q <= 8'd0;
    end else begin
      // output valid: loaded by the engine, dropped once taken
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            rd_vld_q <= row_vld_q[head_i.row[RW-1:0]];
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            if (op_q.cmd == CMD_CLEAR) begin
              row_vld_q <= '0;
            end else if (wr_en) begin
              row_vld_q[op_row] <= 1'b1;
            end
            coll_q      <= coll_nxt;
            out_coll_q  <= coll_nxt;
            out_done_q  <= done_nxt;
            out_group_q <= group_nxt;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_valid_o     = out_valid_q;
  assign m_collision_o = out_coll_q;
  assign m_done_o      = out_done_q;
  assign m_group_o     = out_group_q;

endmodule

FILE: hw/rtl/xor_sprite_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_unit: one-bit-per-pixel sprite framebuffer
// Clear, XOR sprite row draw with collision detect, and eight-pixel read.
// ----------------------------------------------------------------------------
// Each command returns exactly one result item. Commands are decoded and
// queued (two entries), then a row engine executes them one at a time: in
// its idle state it pops a command and reads the target row from the frame
// memory through its registered read port, and in its execute state it
// updates the row and loads the output register, waiting there while the
// last result has not been taken. A clear takes effect at once through
// per-row valid bits, so there is no clearing pass after reset. Write
// wrap_enable on the cfg channel only while no item is in flight.
module xor_sprite_framebuffer_unit
  import xsf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // wrap_enable
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[7:0], pos_y[15:8], row_index[19:16], sprite_byte[27:20],
  // first_row[28], zero[31:29]
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  input  logic        s_axis_tlast,   // last_row
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // collision[0], pixel_group[8:1], zero[15:9]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast    // sprite_done
);

  logic    wrap_q;
  xsf_op_t dec_op;
  xsf_op_t head_op;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    push;
  logic    res_coll;
  logic    res_done;
  logic [7:0] res_group;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wrap_q <= cfg_data_i;
    end
  end

  // decode
  xsf_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .cmd_i         (s_axis_tuser),
    .pos_x_i       (s_axis_tdata[7:0]),
    .pos_y_i       (s_axis_tdata[15:8]),
    .row_index_i   (s_axis_tdata[19:16]),
    .sprite_byte_i (s_axis_tdata[27:20]),
    .first_row_i   (s_axis_tdata[28]),
    .last_row_i    (s_axis_tlast),
    .wrap_i        (wrap_q),
    .op_o          (dec_op)
  );

  // queue between decode and row engine
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  xsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (dec_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (head_op),
    .empty_o (q_empty)
  );

  // row engine
  xsf_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wrap_i        (wrap_q),
    .head_i        (head_op),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_collision_o (res_coll),
    .m_done_o      (res_done),
    .m_group_o     (res_group)
  );

  // result packing
  assign m_axis_tdata = {7'd0, res_group, res_coll};
  assign m_axis_tlast = res_done;

endmodule
